### src/wcpb_pkg.sv
// Shared types and constants for the word clock phrase builder.
// Word codes, configuration layout and the phrase record. No dependencies.
package wcpb_pkg;

  localparam int unsigned MaxWords = 7;

  typedef logic [5:0] word_t;
  typedef logic [2:0] wcount_t;

  // word codes
  localparam word_t W_NOON      = 6'd0;
  localparam word_t W_MIDNIGHT  = 6'd1;
  localparam word_t W_NIGHT     = 6'd2;
  localparam word_t W_DAWN      = 6'd3;
  localparam word_t W_MORNING   = 6'd4;
  localparam word_t W_FORENOON  = 6'd5;
  localparam word_t W_AFTERNOON = 6'd6;
  localparam word_t W_EVENING   = 6'd7;
  localparam word_t W_QUARTER   = 6'd8;
  localparam word_t W_HALF      = 6'd9;
  localparam word_t W_THREEQ    = 6'd10;
  localparam word_t W_HOUR1     = 6'd11;
  localparam word_t W_MIN1      = 6'd23;
  localparam word_t W_PAST      = 6'd31;
  localparam word_t W_PASTSFX   = 6'd32;
  localparam word_t W_WILLBE    = 6'd33;
  localparam word_t W_MINUTE    = 6'd34;
  localparam word_t W_FROMNOW   = 6'd35;

  // register indexes
  localparam logic [2:0] REG_DAWN     = 3'd0;
  localparam logic [2:0] REG_MORNING  = 3'd1;
  localparam logic [2:0] REG_FORENOON = 3'd2;
  localparam logic [2:0] REG_NOON     = 3'd3;
  localparam logic [2:0] REG_EVENING  = 3'd4;

  // reset values
  localparam logic [4:0] RST_DAWN     = 5'd4;
  localparam logic [4:0] RST_MORNING  = 5'd6;
  localparam logic [4:0] RST_FORENOON = 5'd10;
  localparam logic [4:0] RST_NOON     = 5'd12;
  localparam logic [4:0] RST_EVENING  = 5'd18;

  typedef struct packed {
    logic [4:0] dawn_start;
    logic [4:0] morning_start;
    logic [4:0] forenoon_start;
    logic [4:0] noon_start;
    logic [4:0] evening_start;
  } cfg_t;

  typedef struct packed {
    word_t [MaxWords-1:0] words;
    wcount_t              count;
  } phrase_t;

  typedef struct packed {
    logic busy;     // phrase buffer holds words
    logic loading;  // phrase buffer takes a new phrase this cycle
  } ser_stat_t;

endpackage

### src/wcpb_regs.sv
// APB configuration registers: the five day-period boundaries.
// Depends on wcpb_pkg.
module wcpb_regs import wcpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dawn_start     <= RST_DAWN;
      cfg.morning_start  <= RST_MORNING;
      cfg.forenoon_start <= RST_FORENOON;
      cfg.noon_start     <= RST_NOON;
      cfg.evening_start  <= RST_EVENING;
    end else if (wr) begin
      unique case (idx)
        REG_DAWN:     cfg.dawn_start     <= pwdata[4:0];
        REG_MORNING:  cfg.morning_start  <= pwdata[4:0];
        REG_FORENOON: cfg.forenoon_start <= pwdata[4:0];
        REG_NOON:     cfg.noon_start     <= pwdata[4:0];
        REG_EVENING:  cfg.evening_start  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_DAWN:     prdata = {27'd0, cfg.dawn_start};
      REG_MORNING:  prdata = {27'd0, cfg.morning_start};
      REG_FORENOON: prdata = {27'd0, cfg.forenoon_start};
      REG_NOON:     prdata = {27'd0, cfg.noon_start};
      REG_EVENING:  prdata = {27'd0, cfg.evening_start};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

### src/wcpb_phrase.sv
// Combinational phrase builder: hour and minute to a packed list of word codes.
// Depends on wcpb_pkg.
module wcpb_phrase import wcpb_pkg::*; (
  input  logic [4:0] hour_in,
  input  logic [5:0] minute_in,
  input  cfg_t       cfg,
  output phrase_t    phrase
);

  localparam logic [2:0] A_WHOLE = 3'd0;
  localparam logic [2:0] A_QTR   = 3'd1;
  localparam logic [2:0] A_HALF  = 3'd2;
  localparam logic [2:0] A_THREE = 3'd3;
  localparam logic [2:0] A_NEXT  = 3'd4;

  logic [4:0] hour, shown;
  logic [5:0] minute, target, diff;
  logic [2:0] anchor;
  logic [3:0] num;
  logic       whole;
  word_t      period;

  always_comb begin
    hour   = (hour_in >= 5'd24) ? hour_in - 5'd24 : hour_in;
    minute = (minute_in > 6'd59) ? 6'd59 : minute_in;

    priority if (minute <= 6'd8) begin
      anchor = A_WHOLE; target = 6'd0;
    end else if (minute <= 6'd23) begin
      anchor = A_QTR;   target = 6'd15;
    end else if (minute <= 6'd38) begin
      anchor = A_HALF;  target = 6'd30;
    end else if (minute <= 6'd53) begin
      anchor = A_THREE; target = 6'd45;
    end else begin
      anchor = A_NEXT;  target = 6'd60;
    end

    if (anchor == A_WHOLE) shown = hour;
    else                   shown = (hour == 5'd23) ? 5'd0 : hour + 5'd1;
    whole = (anchor == A_WHOLE) || (anchor == A_NEXT);

    if (shown > 5'd12)      num = 4'(shown - 5'd12);
    else if (shown == 5'd0) num = 4'd12;
    else                    num = shown[3:0];

    // day period from the actual hour, first match wins
    priority if (hour < cfg.dawn_start)          period = W_NIGHT;
    else if (hour < cfg.morning_start)           period = W_DAWN;
    else if (hour < cfg.forenoon_start)          period = W_MORNING;
    else if (hour < cfg.noon_start)              period = W_FORENOON;
    else if (hour == 5'd12)                      period = W_AFTERNOON;
    else if (hour > 5'd12 && hour < cfg.evening_start) period = W_AFTERNOON;
    else                                         period = W_EVENING;

    diff = (minute > target) ? minute - target : target - minute;
  end

  always_comb begin
    word_t [MaxWords-1:0] w;
    wcount_t              n;
    w = '0;
    n = '0;
    if (shown != 5'd0 && shown != 5'd12) begin
      w[n] = period; n = n + 3'd1;
    end
    unique case (anchor)
      A_QTR:   begin w[n] = W_QUARTER; n = n + 3'd1; end
      A_HALF:  begin w[n] = W_HALF;    n = n + 3'd1; end
      A_THREE: begin w[n] = W_THREEQ;  n = n + 3'd1; end
      default: ;
    endcase
    if (whole && shown == 5'd12)     w[n] = W_NOON;
    else if (whole && shown == 5'd0) w[n] = W_MIDNIGHT;
    else                             w[n] = W_HOUR1 + {2'd0, num} - 6'd1;
    n = n + 3'd1;
    if (minute > target) begin
      w[n] = W_PAST;                  n = n + 3'd1;
      w[n] = W_MIN1 + diff - 6'd1;    n = n + 3'd1;
      w[n] = W_PASTSFX;               n = n + 3'd1;
    end else if (minute < target) begin
      w[n] = W_WILLBE;                n = n + 3'd1;
      w[n] = W_MIN1 + diff - 6'd1;    n = n + 3'd1;
      w[n] = W_MINUTE;                n = n + 3'd1;
      w[n] = W_FROMNOW;               n = n + 3'd1;
    end
    phrase.words = w;
    phrase.count = n;
  end

endmodule

### src/wcpb_serializer.sv
// Phrase buffer and word sequencer: holds one built phrase and sends its words
// one transfer per cycle while m_tready is high. Depends on wcpb_pkg.
module wcpb_serializer import wcpb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      phrase_valid,
  input  phrase_t   phrase,
  output logic      phrase_take,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic [7:0] m_tdata,
  output logic      m_tlast,
  output ser_stat_t stat
);

  word_t [MaxWords-1:0] words;
  wcount_t              count;
  logic                 busy;
  logic [2:0]           idx;
  logic                 xfer;

  assign m_tvalid = busy;
  assign m_tlast  = (idx == count - 3'd1);
  assign m_tdata  = {2'd0, words[idx]};
  assign xfer     = busy && m_tready;

  // refill when empty or when the final word leaves this cycle
  assign phrase_take = phrase_valid && (!busy || (xfer && m_tlast));

  assign stat.busy    = busy;
  assign stat.loading = phrase_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (phrase_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (m_tlast) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phrase_take) begin
      words <= phrase.words;
      count <= phrase.count;
    end
  end

endmodule

### src/word_clock_phrase_builder.sv
// Word clock phrase builder: one input transfer (hour, minute) yields a phrase of
// one to seven word codes in Hungarian quarter-hour phrasing, sent one word per
// output transfer with tlast on the final word. An accepted item sits in an input
// register, the phrase is built combinationally from it and loaded into the phrase
// buffer, which drives the output port directly. The next item is taken into the
// input register while the current phrase drains and is loaded with no bubble as
// the last word leaves, so the output port, which sends one word per cycle while
// m_tready is high, sets the sustained throughput. From an empty buffer, an item
// passes through the input register and then the phrase buffer before its first
// word appears on the output. Day-period boundaries are set through the APB port
// (registers at byte addresses 0, 4, 8, 12, 16) and should only be written while
// the block is idle.
// Depends on wcpb_pkg, wcpb_regs, wcpb_phrase, wcpb_serializer.
module word_clock_phrase_builder import wcpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [4:0] hour_in, [10:5] minute_in, [15:11] zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [5:0] word_code, [7:6] zero
  output logic        m_tlast   // last_word
);

  cfg_t       cfg;
  phrase_t    phrase;
  ser_stat_t  stat;
  logic       in_valid;
  logic [4:0] hour;
  logic [5:0] minute;
  logic       phrase_take;
  logic       s_xfer;

  wcpb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: freed when its item moves into the phrase buffer
  assign s_tready = !in_valid || phrase_take;
  assign s_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (phrase_take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      hour   <= s_tdata[4:0];
      minute <= s_tdata[10:5];
    end
  end

  wcpb_phrase u_phrase (
    .hour_in   (hour),
    .minute_in (minute),
    .cfg       (cfg),
    .phrase    (phrase)
  );

  wcpb_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .phrase_valid (in_valid),
    .phrase       (phrase),
    .phrase_take  (phrase_take),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .stat         (stat)
  );

  // An empty input register always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input register empty but not ready");

  // A phrase never ends before its final word
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("phrase dropped before last word");

  // A waiting item follows the last word with no bubble
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && in_valid) |=> (m_tvalid && $past(stat.loading)))
    else $error("bubble between phrases");

  // The buffer loads only when empty or draining its last word
  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    stat.loading |-> (!stat.busy || (m_tready && m_tlast)))
    else $error("phrase buffer overwritten");

endmodule
